FILE: rtl/core/rtcb_pkg.sv
// Shared types, constants and BCD helper for the serial RTC burst reader.
// No dependencies.
`default_nettype none

package rtcb_pkg;

    localparam logic [7:0] CMD_BURST_READ  = 8'hBF;
    localparam logic [7:0] STEP_IDLE       = 8'd0;
    localparam logic [7:0] STEP_CMD_FIRST  = 8'd1;
    localparam logic [7:0] STEP_READ_FIRST = 8'd17;
    localparam logic [7:0] STEP_FINISH     = 8'd129;

    localparam logic [2:0] BYTE_SECOND  = 3'd0;
    localparam logic [2:0] BYTE_MINUTE  = 3'd1;
    localparam logic [2:0] BYTE_HOUR    = 3'd2;
    localparam logic [2:0] BYTE_DAY     = 3'd3;
    localparam logic [2:0] BYTE_MONTH   = 3'd4;
    localparam logic [2:0] BYTE_WEEKDAY = 3'd5;
    localparam logic [2:0] BYTE_YEAR    = 3'd6;

    localparam logic [6:0]  PIVOT_RESET = 7'd80;
    localparam logic [6:0]  HOUR_NOON   = 7'd12;
    localparam logic [11:0] YEAR_1900   = 12'd1900;
    localparam logic [11:0] YEAR_2000   = 12'd2000;

    typedef struct packed {
        logic ce;
        logic sclk;
        logic dout;
        logic drive;
        logic busy;
    } t_pins;

    typedef struct packed {
        logic       strobe;
        logic [2:0] index;
        logic [7:0] raw;
    } t_byte_evt;

    function automatic logic [6:0] bcd_byte(input logic [7:0] v);
        logic [6:0] tens;
        logic [6:0] ones;
        tens = (v[7:4] > 4'd9) ? 7'd0 : {3'b000, v[7:4]};
        ones = (v[3:0] > 4'd9) ? 7'd0 : {3'b000, v[3:0]};
        return (tens << 3) + (tens << 1) + ones;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rtcb_if.sv
// Valid/ready channel interfaces for the serial RTC burst reader.
// Standalone; no package dependency.
`default_nettype none

interface rtcb_item_if;
    logic valid;
    logic ready;
    logic start_req;
    logic sampled_io;

    modport source (output valid, start_req, sampled_io, input ready);
    modport sink   (input valid, start_req, sampled_io, output ready);
endinterface

interface rtcb_result_if;
    logic        valid;
    logic        ready;
    logic        chip_enable;
    logic        serial_clock;
    logic        data_out;
    logic        data_drive;
    logic        busy_res;
    logic        time_valid;
    logic [6:0]  second;
    logic [6:0]  minute;
    logic [6:0]  hour;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [11:0] year;

    modport source (output valid, chip_enable, serial_clock, data_out, data_drive,
                    busy_res, time_valid, second, minute, hour, day, month, year,
                    input ready);
    modport sink   (input valid, chip_enable, serial_clock, data_out, data_drive,
                    busy_res, time_valid, second, minute, hour, day, month, year,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rtcb_sequencer.sv
// Half-bit sequencer: step counter, shift register and pin levels.
// Uses rtcb_pkg. Emits a byte event when a read byte completes.
`default_nettype none

module rtcb_sequencer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_advance,
    input  wire logic               i_start_req,
    input  wire logic               i_sampled_io,
    output rtcb_pkg::t_pins         o_pins,
    output rtcb_pkg::t_byte_evt     o_byte_evt,
    output logic                    o_finish
);

    logic [7:0]      r_step, n_step;
    logic [7:0]      r_shift, n_shift;
    rtcb_pkg::t_pins r_pins, n_pins;
    logic [3:0]      cmd_idx;
    logic [6:0]      rd_idx;
    logic [7:0]      step_cmd;
    logic [7:0]      step_rd;

    assign step_cmd = r_step - rtcb_pkg::STEP_CMD_FIRST;
    assign step_rd  = r_step - rtcb_pkg::STEP_READ_FIRST;
    assign cmd_idx  = step_cmd[3:0];
    assign rd_idx   = step_rd[6:0];

    always_comb begin
        n_step     = r_step;
        n_shift    = r_shift;
        n_pins     = r_pins;
        o_byte_evt = '0;
        o_finish   = 1'b0;
        priority if (r_step == rtcb_pkg::STEP_IDLE) begin
            if (i_start_req) begin
                n_pins = '{ce: 1'b1, sclk: 1'b0, dout: 1'b0, drive: 1'b0, busy: 1'b1};
                n_step = rtcb_pkg::STEP_CMD_FIRST;
            end
        end else if (r_step < rtcb_pkg::STEP_READ_FIRST) begin
            if (!cmd_idx[0]) begin
                n_pins.sclk  = 1'b0;
                n_pins.drive = 1'b1;
                n_pins.dout  = rtcb_pkg::CMD_BURST_READ[cmd_idx[3:1]];
            end else begin
                n_pins.sclk = 1'b1;
            end
            n_step = r_step + 8'd1;
        end else if (r_step < rtcb_pkg::STEP_FINISH) begin
            if (!rd_idx[0]) begin
                n_pins.sclk  = 1'b0;
                n_pins.drive = 1'b0;
                n_pins.dout  = 1'b0;
                n_shift      = {i_sampled_io, r_shift[7:1]};
                if (rd_idx[3:1] == 3'd7) begin
                    o_byte_evt.strobe = i_advance;
                    o_byte_evt.index  = rd_idx[6:4];
                    o_byte_evt.raw    = n_shift;
                end
            end else begin
                n_pins.sclk = 1'b1;
            end
            n_step = r_step + 8'd1;
        end else begin
            n_pins   = '0;
            o_finish = 1'b1;
            n_step   = rtcb_pkg::STEP_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= rtcb_pkg::STEP_IDLE;
            r_shift <= '0;
            r_pins  <= '0;
        end else if (i_advance) begin
            r_step  <= n_step;
            r_shift <= n_shift;
            r_pins  <= n_pins;
        end
    end

    assign o_pins = r_pins;

endmodule

`default_nettype wire

FILE: rtl/core/rtcb_time_regs.sv
// Time field registers with BCD decode, 12/24-hour and century windowing.
// Uses rtcb_pkg; fed by byte events from rtcb_sequencer.
`default_nettype none

module rtcb_time_regs (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire rtcb_pkg::t_byte_evt i_byte_evt,
    input  wire logic [6:0]          i_year_pivot,
    output logic [6:0]               o_second,
    output logic [6:0]               o_minute,
    output logic [6:0]               o_hour,
    output logic [6:0]               o_day,
    output logic [6:0]               o_month,
    output logic [11:0]              o_year
);

    logic [6:0]  r_second, r_minute, r_hour, r_day, r_month;
    logic [11:0] r_year;
    logic [6:0]  dec_full;
    logic [6:0]  dec_sec;
    logic [6:0]  dec_h12;
    logic [6:0]  hour_12;
    logic [6:0]  hour_val;
    logic [11:0] year_val;

    assign dec_full = rtcb_pkg::bcd_byte(i_byte_evt.raw);
    assign dec_sec  = rtcb_pkg::bcd_byte({1'b0, i_byte_evt.raw[6:0]});
    assign dec_h12  = rtcb_pkg::bcd_byte({3'b000, i_byte_evt.raw[4:0]});

    always_comb begin
        hour_12 = (dec_h12 == rtcb_pkg::HOUR_NOON) ? 7'd0 : dec_h12;
        if (i_byte_evt.raw[5]) begin
            hour_12 = hour_12 + rtcb_pkg::HOUR_NOON;
        end
        hour_val = i_byte_evt.raw[7] ? hour_12 : dec_full;
        year_val = ((dec_full >= i_year_pivot) ? rtcb_pkg::YEAR_1900 : rtcb_pkg::YEAR_2000)
                   + {5'b00000, dec_full};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= '0;
            r_minute <= '0;
            r_hour   <= '0;
            r_day    <= '0;
            r_month  <= '0;
            r_year   <= rtcb_pkg::YEAR_1900;
        end else if (i_byte_evt.strobe) begin
            unique case (i_byte_evt.index)
                rtcb_pkg::BYTE_SECOND: r_second <= dec_sec;
                rtcb_pkg::BYTE_MINUTE: r_minute <= dec_full;
                rtcb_pkg::BYTE_HOUR:   r_hour   <= hour_val;
                rtcb_pkg::BYTE_DAY:    r_day    <= dec_full;
                rtcb_pkg::BYTE_MONTH:  r_month  <= dec_full;
                rtcb_pkg::BYTE_YEAR:   r_year   <= year_val;
                rtcb_pkg::BYTE_WEEKDAY: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_second = r_second;
    assign o_minute = r_minute;
    assign o_hour   = r_hour;
    assign o_day    = r_day;
    assign o_month  = r_month;
    assign o_year   = r_year;

endmodule

`default_nettype wire

FILE: rtl/core/serial_rtc_burst_reader.sv
// Serial RTC burst reader top: one item per tick, one result per item.
// The result is registered at the edge that accepts the item.
// Throughput 1 item per cycle; input ready stays high while the result register is
// empty or being drained, so a stalled result blocks only the next item.
// Reset (synchronous, active low): sequence idle, pins low, time 0 and year 1900,
// year pivot 80, no result pending. Uses rtcb_pkg, rtcb_if, sequencer, time regs.
`default_nettype none

module serial_rtc_burst_reader (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [6:0]    i_cfg_wr_data,
    rtcb_item_if.sink          i_item,
    rtcb_result_if.source      o_result
);

    logic                r_out_valid;
    logic                r_time_valid;
    logic [6:0]          r_year_pivot;
    logic                advance;
    logic                finish;
    rtcb_pkg::t_pins     pins;
    rtcb_pkg::t_byte_evt byte_evt;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign advance      = i_item.valid && i_item.ready;

    rtcb_sequencer u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_start_req  (i_item.start_req),
        .i_sampled_io (i_item.sampled_io),
        .o_pins       (pins),
        .o_byte_evt   (byte_evt),
        .o_finish     (finish)
    );

    rtcb_time_regs u_time (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_evt   (byte_evt),
        .i_year_pivot (r_year_pivot),
        .o_second     (o_result.second),
        .o_minute     (o_result.minute),
        .o_hour       (o_result.hour),
        .o_day        (o_result.day),
        .o_month      (o_result.month),
        .o_year       (o_result.year)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_time_valid <= 1'b0;
            r_year_pivot <= rtcb_pkg::PIVOT_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_year_pivot <= i_cfg_wr_data;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_time_valid <= finish;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.chip_enable  = pins.ce;
    assign o_result.serial_clock = pins.sclk;
    assign o_result.data_out     = pins.dout;
    assign o_result.data_drive   = pins.drive;
    assign o_result.busy_res     = pins.busy;
    assign o_result.time_valid   = r_time_valid;

endmodule

`default_nettype wire

FILE: rtl/core/rtcb_checker.sv
// Port-level assertions for serial_rtc_burst_reader, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module rtcb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_ce,
    input wire logic        i_sclk,
    input wire logic        i_dout,
    input wire logic        i_drive,
    input wire logic        i_busy,
    input wire logic        i_time_valid,
    input wire logic [11:0] i_year
);

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_time_valid) |-> (!i_busy && !i_ce && !i_sclk && !i_drive))
        else $error("time_valid with lines not idle");

    a_dout_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_drive) |-> !i_dout)
        else $error("data_out high while line released");

    a_busy_ce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_busy == i_ce))
        else $error("busy and chip enable disagree");

    a_ce_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_ce) |-> !i_sclk)
        else $error("serial clock toggles with chip enable off");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_year)
                                           && $stable(i_time_valid)))
        else $error("stalled item changed");

endmodule

bind serial_rtc_burst_reader rtcb_checker u_rtcb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_ce         (o_result.chip_enable),
    .i_sclk       (o_result.serial_clock),
    .i_dout       (o_result.data_out),
    .i_drive      (o_result.data_drive),
    .i_busy       (o_result.busy_res),
    .i_time_valid (o_result.time_valid),
    .i_year       (o_result.year)
);

`default_nettype wire
